/* src/lsft_pkg.sv */
// Package with the types, template constants and helpers of the landmark similarity fit.
package lsft_pkg;

  localparam int NUM_POINTS = 5;
  localparam int WW         = 128;
  localparam int PW         = 24;

  typedef logic [WW-1:0] wide_t;
  typedef logic signed [PW-1:0] coord_t;

  localparam logic [63:0] DENC_112 = 64'd1120000;
  localparam logic [63:0] DENC_128 = 64'd1280000;
  localparam logic [63:0] DENS_112 = 64'd5600000;
  localparam logic [63:0] DENS_128 = 64'd6400000;
  localparam logic [63:0] TSX_112  = 64'd2801308;
  localparam logic [63:0] TSX_128  = 64'd3201308;
  localparam logic [63:0] TSY      = 64'd3595039;

  // Demeaned template x, scaled by the point count, in units of 1e-4 pixel.
  function automatic coord_t tpl_dx(input logic [2:0] idx);
    coord_t v;
    case (idx)
      3'd0: v = -24'sd886578;
      3'd1: v = 24'sd875282;
      3'd2: v = -24'sd48;
      3'd3: v = -24'sd723843;
      3'd4: v = 24'sd735187;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic coord_t tpl_dy(input logic [2:0] idx);
    coord_t v;
    case (idx)
      3'd0: v = -24'sd1010224;
      3'd1: v = -24'sd1019969;
      3'd2: v = -24'sd8209;
      3'd3: v = 24'sd1023236;
      3'd4: v = 24'sd1015166;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic size_mult_112(input logic [10:0] size);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 19; k++) begin
      if (size == 11'(k * 112)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

/* src/landmark_similarity_transform_fit_unit.sv */
// Top level of the five-point landmark similarity fit with its shared arithmetic unit.
//
// Landmarks are taken one per cycle while the block is idle. The fifth point of a
// set starts the fit, and the block is not ready until the result has been
// handed to the output register. Multiplies and divisions run through one 128-bit
// adder: shift-and-add multiplies (one multiplier bit per cycle) and restoring
// divisions (one quotient bit per cycle, 128 steps plus rounding). The length
// of a fit is set by the operand bit lengths of its 43 multiplies and by its
// five divisions; a zero-variance set finishes after the three accumulation
// passes. The output register lets the next set be gathered while a result
// waits to be taken.
module landmark_similarity_transform_fit_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // point_x [23:0], point_y [47:24]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // coef_xx, coef_xy, shift_x, coef_yx, coef_yy, shift_y
  output logic [0:0]   out_tuser,  // degenerate [0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [10:0]  cfg_data
);
  import lsft_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SUM  = 4'd1;
  localparam logic [3:0] ST_LOAD = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_DABS = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_RND  = 4'd6;
  localparam logic [3:0] ST_INC  = 4'd7;
  localparam logic [3:0] ST_SAT  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  localparam logic [4:0] OP_VAR_X = 5'd0;
  localparam logic [4:0] OP_VAR_Y = 5'd1;
  localparam logic [4:0] OP_SA_X  = 5'd2;
  localparam logic [4:0] OP_SA_Y  = 5'd3;
  localparam logic [4:0] OP_SB_X  = 5'd4;
  localparam logic [4:0] OP_SB_Y  = 5'd5;
  localparam logic [4:0] OP_DENC  = 5'd6;
  localparam logic [4:0] OP_DENS  = 5'd7;
  localparam logic [4:0] OP_N0    = 5'd8;
  localparam logic [4:0] OP_N1    = 5'd9;
  localparam logic [4:0] OP_N3    = 5'd10;
  localparam logic [4:0] OP_TX0   = 5'd11;
  localparam logic [4:0] OP_TX1   = 5'd12;
  localparam logic [4:0] OP_TX2   = 5'd13;
  localparam logic [4:0] OP_TXS   = 5'd14;
  localparam logic [4:0] OP_TY0   = 5'd15;
  localparam logic [4:0] OP_TY1   = 5'd16;
  localparam logic [4:0] OP_TY2   = 5'd17;
  localparam logic [4:0] OP_TYS   = 5'd18;

  localparam logic [2:0] LAST_PT = 3'(NUM_POINTS - 1);

  logic [3:0]         state_r;
  logic [4:0]         pc_r;
  logic [2:0]         i_r;
  logic [2:0]         count_r;
  logic [6:0]         cnt_r;
  logic [10:0]        size_r;
  logic [47:0]        store_r [NUM_POINTS];
  logic signed [26:0] sumx_r, sumy_r;
  logic signed [63:0] var_r, sa_r, sb_r;
  wide_t              dc_r, ds_r, acc_r, a_r;
  logic [63:0]        b_r;
  logic               sub_r, neg_r, dsel_r, degen_r;
  logic [31:0]        res_xx_r, res_xy_r, res_yx_r, res_sx_r, res_sy_r;
  logic [191:0]       out_data_r;
  logic               out_user_r, out_valid_r;

  logic [47:0]        cur_pt;
  coord_t             px, py;
  logic signed [27:0] px_e, py_e, sx, sy;
  logic               d128;
  wide_t              a_src;
  logic signed [63:0] b_src;
  logic [63:0]        b_mag;
  logic               op_clr, op_neg;
  wide_t              add_x, add_y, rs, den;
  logic               add_sub;
  logic [WW:0]        add_res;
  logic               sat_pos, sat_neg;
  logic [31:0]        mag32, resv;

  assign cur_pt = store_r[i_r];
  assign px     = cur_pt[23:0];
  assign py     = cur_pt[47:24];
  assign px_e   = 28'(px);
  assign py_e   = 28'(py);
  assign sx     = (px_e <<< 2) + px_e - 28'(sumx_r);
  assign sy     = (py_e <<< 2) + py_e - 28'(sumy_r);
  assign d128   = !size_mult_112(size_r);

  always_comb begin
    a_src  = '0;
    b_src  = '0;
    op_clr = 1'b0;
    op_neg = 1'b0;
    case (pc_r)
      OP_VAR_X: begin a_src = WW'(sx); b_src = 64'(sx); op_clr = (i_r == '0); end
      OP_VAR_Y: begin a_src = WW'(sy); b_src = 64'(sy); end
      OP_SA_X:  begin a_src = WW'(sx); b_src = 64'(tpl_dx(i_r)); op_clr = (i_r == '0); end
      OP_SA_Y:  begin a_src = WW'(sy); b_src = 64'(tpl_dy(i_r)); end
      OP_SB_X:  begin a_src = WW'(sx); b_src = 64'(tpl_dy(i_r)); op_clr = (i_r == '0); end
      OP_SB_Y:  begin a_src = WW'(sy); b_src = 64'(tpl_dx(i_r)); op_neg = 1'b1; end
      OP_DENC: begin
        a_src = WW'(var_r); b_src = d128 ? DENC_128 : DENC_112; op_clr = 1'b1;
      end
      OP_DENS: begin
        a_src = WW'(var_r); b_src = d128 ? DENS_128 : DENS_112; op_clr = 1'b1;
      end
      OP_N0: begin a_src = WW'(sa_r); b_src = 64'(size_r); op_clr = 1'b1; end
      OP_N1: begin a_src = WW'(sb_r); b_src = 64'(size_r); op_clr = 1'b1; op_neg = 1'b1; end
      OP_N3: begin a_src = WW'(sb_r); b_src = 64'(size_r); op_clr = 1'b1; end
      OP_TX0: begin
        a_src = WW'(var_r); b_src = d128 ? TSX_128 : TSX_112; op_clr = 1'b1;
      end
      OP_TX1: begin a_src = WW'(sa_r); b_src = 64'(sumx_r); op_neg = 1'b1; end
      OP_TX2: begin a_src = WW'(sb_r); b_src = 64'(sumy_r); end
      OP_TXS: begin a_src = acc_r; b_src = 64'(size_r); op_clr = 1'b1; end
      OP_TY0: begin a_src = WW'(var_r); b_src = TSY; op_clr = 1'b1; end
      OP_TY1: begin a_src = WW'(sb_r); b_src = 64'(sumx_r); op_neg = 1'b1; end
      OP_TY2: begin a_src = WW'(sa_r); b_src = 64'(sumy_r); op_neg = 1'b1; end
      OP_TYS: begin a_src = acc_r; b_src = 64'(size_r); op_clr = 1'b1; end
      default: begin a_src = '0; b_src = '0; end
    endcase
  end

  assign b_mag = b_src[63] ? 64'(-b_src) : 64'(b_src);
  assign rs    = {acc_r[WW-2:0], a_r[WW-1]};
  assign den   = dsel_r ? ds_r : dc_r;

  always_comb begin
    add_x   = acc_r;
    add_y   = a_r;
    add_sub = sub_r;
    case (state_r)
      ST_MUL:  begin add_x = acc_r; add_y = a_r; add_sub = sub_r; end
      ST_DABS: begin add_x = '0; add_y = a_r; add_sub = 1'b1; end
      ST_DIV:  begin add_x = rs; add_y = den; add_sub = 1'b1; end
      ST_RND:  begin add_x = {acc_r[WW-2:0], 1'b0}; add_y = den; add_sub = 1'b1; end
      ST_INC:  begin add_x = a_r; add_y = WW'(1); add_sub = 1'b0; end
      default: begin add_x = acc_r; add_y = a_r; add_sub = sub_r; end
    endcase
  end

  assign add_res = {1'b0, add_x} + {1'b0, add_y ^ {WW{add_sub}}} + (WW+1)'(add_sub);

  assign sat_pos = |a_r[WW-1:31];
  assign sat_neg = (|a_r[WW-1:32]) || (a_r[31] && (|a_r[30:0]));
  assign mag32   = neg_r ? (sat_neg ? 32'h8000_0000 : a_r[31:0])
                         : (sat_pos ? 32'h7FFF_FFFF : a_r[31:0]);
  assign resv    = neg_r ? 32'(-mag32) : mag32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= OP_VAR_X;
      i_r         <= '0;
      count_r     <= '0;
      cnt_r       <= '0;
      size_r      <= 11'd112;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) size_r <= cfg_data;
      if (out_valid_r && out_tready && (state_r != ST_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            store_r[count_r] <= in_tdata;
            if (count_r >= LAST_PT) begin
              count_r <= '0;
              i_r     <= '0;
              sumx_r  <= '0;
              sumy_r  <= '0;
              state_r <= ST_SUM;
            end else begin
              count_r <= count_r + 3'd1;
            end
          end
        end
        ST_SUM: begin
          sumx_r <= sumx_r + 27'(px);
          sumy_r <= sumy_r + 27'(py);
          if (i_r == LAST_PT) begin
            i_r     <= '0;
            pc_r    <= OP_VAR_X;
            state_r <= ST_LOAD;
          end else begin
            i_r <= i_r + 3'd1;
          end
        end
        ST_LOAD: begin
          a_r   <= a_src;
          b_r   <= b_mag;
          sub_r <= op_neg ^ b_src[63];
          if (op_clr) acc_r <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (b_r == '0) begin
            state_r <= ST_LOAD;
            case (pc_r)
              OP_VAR_X: pc_r <= OP_VAR_Y;
              OP_SA_X:  pc_r <= OP_SA_Y;
              OP_SB_X:  pc_r <= OP_SB_Y;
              OP_VAR_Y, OP_SA_Y: begin
                if (i_r == LAST_PT) begin
                  i_r <= '0;
                  if (pc_r == OP_VAR_Y) begin
                    var_r <= acc_r[63:0];
                    pc_r  <= OP_SA_X;
                  end else begin
                    sa_r <= acc_r[63:0];
                    pc_r <= OP_SB_X;
                  end
                end else begin
                  i_r  <= i_r + 3'd1;
                  pc_r <= (pc_r == OP_VAR_Y) ? OP_VAR_X : OP_SA_X;
                end
              end
              OP_SB_Y: begin
                if (i_r == LAST_PT) begin
                  i_r  <= '0;
                  sb_r <= acc_r[63:0];
                  if (var_r == '0) begin
                    degen_r <= 1'b1;
                    state_r <= ST_OUT;
                  end else begin
                    degen_r <= 1'b0;
                    pc_r    <= OP_DENC;
                  end
                end else begin
                  i_r  <= i_r + 3'd1;
                  pc_r <= OP_SB_X;
                end
              end
              OP_DENC: begin dc_r <= acc_r; pc_r <= OP_DENS; end
              OP_DENS: begin ds_r <= acc_r; pc_r <= OP_N0; end
              OP_N0, OP_N1, OP_N3: begin
                a_r     <= acc_r << 32;
                dsel_r  <= 1'b0;
                state_r <= ST_DABS;
              end
              OP_TX0: pc_r <= OP_TX1;
              OP_TX1: pc_r <= OP_TX2;
              OP_TX2: pc_r <= OP_TXS;
              OP_TY0: pc_r <= OP_TY1;
              OP_TY1: pc_r <= OP_TY2;
              OP_TY2: pc_r <= OP_TYS;
              OP_TXS, OP_TYS: begin
                a_r     <= acc_r << 16;
                dsel_r  <= 1'b1;
                state_r <= ST_DABS;
              end
              default: state_r <= ST_IDLE;
            endcase
          end else begin
            if (b_r[0]) acc_r <= add_res[WW-1:0];
            a_r <= a_r << 1;
            b_r <= b_r >> 1;
          end
        end
        ST_DABS: begin
          neg_r <= a_r[WW-1];
          if (a_r[WW-1]) a_r <= add_res[WW-1:0];
          acc_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          acc_r <= add_res[WW] ? add_res[WW-1:0] : rs;
          a_r   <= {a_r[WW-2:0], add_res[WW]};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd127) state_r <= ST_RND;
        end
        ST_RND: state_r <= add_res[WW] ? ST_INC : ST_SAT;
        ST_INC: begin
          a_r     <= add_res[WW-1:0];
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          state_r <= ST_LOAD;
          case (pc_r)
            OP_N0:  begin res_xx_r <= resv; pc_r <= OP_N1; end
            OP_N1:  begin res_xy_r <= resv; pc_r <= OP_N3; end
            OP_N3:  begin res_yx_r <= resv; pc_r <= OP_TX0; end
            OP_TXS: begin res_sx_r <= resv; pc_r <= OP_TY0; end
            OP_TYS: begin res_sy_r <= resv; state_r <= ST_OUT; end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= degen_r;
            out_data_r  <= degen_r ? '0 : {res_sy_r, res_xx_r, res_yx_r,
                                           res_sx_r, res_xy_r, res_xx_r};
            state_r     <= ST_IDLE;
          end else begin
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < 3'(NUM_POINTS))
    else $error("point count out of range");

  a_fifth_starts_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && count_r == LAST_PT) |=> (state_r == ST_SUM && !in_tready))
    else $error("fifth point did not start the fit");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("degenerate result carries nonzero coefficients");

endmodule

/* bench/landmark_similarity_transform_fit_unit_test.sv */
// Self-checking testbench for the five-point landmark similarity fit unit.
`timescale 1ns / 1ps

module landmark_similarity_transform_fit_unit_test;
  import lsft_pkg::*;

  typedef struct {
    logic signed [31:0] coef_xx;
    logic signed [31:0] coef_xy;
    logic signed [31:0] shift_x;
    logic signed [31:0] coef_yx;
    logic signed [31:0] coef_yy;
    logic signed [31:0] shift_y;
    logic               degenerate;
  } affine_t;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 9000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [10:0]  cfg_data;

  logic [47:0] pending_points[$];
  affine_t     expected_fits[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_request;
  logic        holding;
  int          hold_count;
  int          quiet_cycles;
  int          error_count;
  int          fit_count;
  int          degenerate_count;
  logic [10:0] crop_size;
  coord_t      set_x[NUM_POINTS];
  coord_t      set_y[NUM_POINTS];
  int          set_fill;

  landmark_similarity_transform_fit_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic signed [31:0] round_div_sat(input logic signed [191:0] num,
                                                        input logic [191:0] den);
    logic         neg;
    logic [191:0] mag;
    logic [191:0] q;
    logic [191:0] r;
    logic [191:0] limit;
    neg = num[191];
    mag = neg ? -num : num;
    q = mag / den;
    r = mag % den;
    if ((r << 1) >= den) q = q + 1;
    limit = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
    if (q > limit) q = limit;
    return neg ? 32'(-q) : 32'(q);
  endfunction

  function automatic affine_t fit_landmarks(input coord_t xs[NUM_POINTS],
                                            input coord_t ys[NUM_POINTS],
                                            input logic [10:0] size);
    affine_t            fit;
    longint             tplx[NUM_POINTS];
    longint             tply[NUM_POINTS];
    longint             sumx, sumy, tsx, tsy, var_sum, sa, sb, sx, sy, dx, dy, d, off;
    logic signed [191:0] den_c, den_s, sc, tx, ty;
    tplx = '{382946, 735318, 560252, 415493, 707299};
    tply = '{516963, 515014, 717366, 923655, 922041};
    sumx = 0; sumy = 0; tsx = 0; tsy = 0; var_sum = 0; sa = 0; sb = 0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      sumx += longint'(xs[i]);
      sumy += longint'(ys[i]);
      tsx += tplx[i];
      tsy += tply[i];
    end
    for (int i = 0; i < NUM_POINTS; i++) begin
      sx = NUM_POINTS * longint'(xs[i]) - sumx;
      sy = NUM_POINTS * longint'(ys[i]) - sumy;
      dx = NUM_POINTS * tplx[i] - tsx;
      dy = NUM_POINTS * tply[i] - tsy;
      var_sum += sx * sx + sy * sy;
      sa += sx * dx + sy * dy;
      sb += sx * dy - sy * dx;
    end
    fit = '{default: '0};
    if (var_sum == 0) begin
      fit.degenerate = 1'b1;
      return fit;
    end
    d = (size % 112 == 0) ? 112 : 128;
    off = (d == 128) ? 80000 : 0;
    den_c = 192'(10000 * d) * 192'(var_sum);
    den_s = den_c * 192'(NUM_POINTS);
    sc = 192'(size) << 32;
    fit.coef_xx = round_div_sat(192'(sa) * sc, den_c);
    fit.coef_xy = round_div_sat(-(192'(sb) * sc), den_c);
    fit.coef_yx = round_div_sat(192'(sb) * sc, den_c);
    fit.coef_yy = fit.coef_xx;
    tx = 192'(tsx + NUM_POINTS * off) * 192'(var_sum) - 192'(sa) * 192'(sumx)
         + 192'(sb) * 192'(sumy);
    ty = 192'(tsy) * 192'(var_sum) - 192'(sb) * 192'(sumx) - 192'(sa) * 192'(sumy);
    fit.shift_x = round_div_sat(tx * (192'(size) << 16), den_s);
    fit.shift_y = round_div_sat(ty * (192'(size) << 16), den_s);
    return fit;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_points.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !holding && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      holding <= 1'b0;
      hold_count <= 0;
    end else if (holding) begin
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES) holding <= 1'b0;
    end else if (hold_request && hold_count == 0) begin
      holding <= 1'b1;
    end
  end

  always @(posedge clk) begin
    affine_t want;
    affine_t got;
    logic    active;
    active = 1'b0;
    if (!rst_n) begin
      crop_size <= 11'd112;
      set_fill <= 0;
      quiet_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        crop_size <= cfg_data;
        active = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        active = 1'b1;
        set_x[set_fill] = in_tdata[23:0];
        set_y[set_fill] = in_tdata[47:24];
        if (set_fill == NUM_POINTS - 1) begin
          expected_fits.push_back(fit_landmarks(set_x, set_y, crop_size));
          set_fill <= 0;
        end else begin
          set_fill <= set_fill + 1;
        end
      end
      if (out_tvalid && out_tready) begin
        active = 1'b1;
        got.coef_xx = out_tdata[31:0];
        got.coef_xy = out_tdata[63:32];
        got.shift_x = out_tdata[95:64];
        got.coef_yx = out_tdata[127:96];
        got.coef_yy = out_tdata[159:128];
        got.shift_y = out_tdata[191:160];
        got.degenerate = out_tuser[0];
        if (expected_fits.size() == 0) begin
          $error("result item with no fit expected");
          error_count++;
        end else begin
          want = expected_fits.pop_front();
          fit_count++;
          if (want.degenerate) degenerate_count++;
          if (got.coef_xx !== want.coef_xx) begin
            $error("coef_xx expected %0d actual %0d", want.coef_xx, got.coef_xx);
            error_count++;
          end
          if (got.coef_xy !== want.coef_xy) begin
            $error("coef_xy expected %0d actual %0d", want.coef_xy, got.coef_xy);
            error_count++;
          end
          if (got.shift_x !== want.shift_x) begin
            $error("shift_x expected %0d actual %0d", want.shift_x, got.shift_x);
            error_count++;
          end
          if (got.coef_yx !== want.coef_yx) begin
            $error("coef_yx expected %0d actual %0d", want.coef_yx, got.coef_yx);
            error_count++;
          end
          if (got.coef_yy !== want.coef_yy) begin
            $error("coef_yy expected %0d actual %0d", want.coef_yy, got.coef_yy);
            error_count++;
          end
          if (got.shift_y !== want.shift_y) begin
            $error("shift_y expected %0d actual %0d", want.shift_y, got.shift_y);
            error_count++;
          end
          if (got.degenerate !== want.degenerate) begin
            $error("degenerate expected %0d actual %0d", want.degenerate, got.degenerate);
            error_count++;
          end
        end
      end
      quiet_cycles <= active ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL landmark_similarity_transform_fit_unit");
        $finish;
      end
    end
  end

  task automatic queue_point(input logic [23:0] x, input logic [23:0] y);
    pending_points.push_back({y, x});
  endtask

  task automatic queue_face_set();
    int          kind;
    int          cx, cy, gain, jitter;
    logic [23:0] v;
    int          tx[NUM_POINTS];
    int          ty[NUM_POINTS];
    tx = '{-4330, 4690, 210, -3510, 4030};
    ty = '{-3130, -3180, 2000, 7280, 7240};
    kind = $urandom_range(19);
    cx = $signed(24'($urandom));
    cy = $signed(24'($urandom));
    if (kind < 13) begin
      gain = $urandom_range(1, 64);
      jitter = $urandom_range(0, 3) == 0 ? 2000 : 40;
      for (int i = 0; i < NUM_POINTS; i++)
        queue_point(24'(cx / 4 + tx[i] * gain / 8 + int'($urandom_range(0, 2 * jitter))
                        - jitter),
                    24'(cy / 4 + ty[i] * gain / 8 + int'($urandom_range(0, 2 * jitter))
                        - jitter));
    end else if (kind < 16) begin
      for (int i = 0; i < NUM_POINTS; i++) queue_point(24'($urandom), 24'($urandom));
    end else if (kind < 18) begin
      for (int i = 0; i < NUM_POINTS; i++)
        queue_point(24'(cx + $urandom_range(0, 2)), 24'(cy + $urandom_range(0, 2)));
    end else begin
      v = 24'($urandom);
      for (int i = 0; i < NUM_POINTS; i++) queue_point(v, 24'(cy));
    end
  endtask

  task automatic drain_and_settle();
    do @(posedge clk);
    while (pending_points.size() > 0 || in_tvalid || expected_fits.size() > 0);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_crop_size(input logic [10:0] size);
    cfg_valid <= 1'b1;
    cfg_data <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [10:0] phase_sizes[6];
    phase_sizes = '{11'd1, 11'd1024, 11'd224, 11'd128, 11'd1008, 11'd0};
    error_count = 0;
    fit_count = 0;
    degenerate_count = 0;
    hold_request = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 56;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Two lines of points, all extremes and a one-step spread.
    for (int i = 0; i < NUM_POINTS; i++)
      queue_point(24'(i * 1000 + 256), 24'(i * 700 - 9000));
    for (int i = 0; i < NUM_POINTS; i++) queue_point(24'h7FFFFF, 24'h800000);
    for (int i = 0; i < NUM_POINTS; i++)
      queue_point(i[0] ? 24'h7FFFFF : 24'h800000, i[1] ? 24'h800000 : 24'h7FFFFF);
    for (int i = 0; i < NUM_POINTS; i++) queue_point(24'(i == 2), 24'h0);
    for (int i = 0; i < NUM_POINTS; i++) queue_point(24'(-i * 5000), 24'(i * 5000));
    drain_and_settle();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 56;
        recv_idle_pct = 37;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_crop_size(p == 5 ? 11'($urandom_range(1, 1024)) : phase_sizes[p]);
      if (p == 4) hold_request = 1'b1;
      for (int s = 0; s < 44; s++) queue_face_set();
      drain_and_settle();
      hold_request = 1'b0;
    end

    $display("Checked %0d fits (%0d with zero variance) over six crop sizes,",
             fit_count, degenerate_count);
    $display("with stalls on both sides and one long receiver hold-off.");
    if (error_count == 0) begin
      $display("PASS landmark_similarity_transform_fit_unit");
    end else begin
      $display("FAIL landmark_similarity_transform_fit_unit");
    end
    $finish;
  end

endmodule
